[src/rrcg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and sine table for the rotated raster coordinate generator.
// No dependencies; every other file imports this package.
package rrcg_pkg;

    localparam int MAX_DIM      = 1024;
    localparam int SINE_ENTRIES = 256;
    localparam int QUARTER      = SINE_ENTRIES / 4;
    localparam int ANGLE_W      = $clog2(SINE_ENTRIES);
    localparam int DIM_CFG_W    = 11;
    localparam int IDX_W        = $clog2(MAX_DIM);
    localparam int SIZE_W       = IDX_W + 1;
    localparam int ACC_W        = 32;
    localparam int COORD_W      = 22;
    localparam int COORD_SHIFT  = 8;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_ADDR_W   = 2;
    localparam int SETTLE_W     = 2;

    localparam logic [ANGLE_W-1:0]   ANGLE_RST     = 8'h00;
    localparam logic [DIM_CFG_W-1:0] DIM_RST       = 11'd64;
    localparam logic [ANGLE_W-1:0]   ANGLE_COS_OFS = 8'h40;
    localparam logic [ANGLE_W-1:0]   ANGLE_NEG_OFS = 8'h80;
    // cycles the derived config pipeline needs after a write or reset
    localparam logic [SETTLE_W-1:0]  CFG_SETTLE    = 2'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ANGLE    = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_HEIGHT   = 2'd2,
        REG_ABS_MODE = 2'd3
    } cfg_index_t;

    // derived per-frame constants; all but the last indices in 16.16 with 2^32 wrap
    typedef struct packed {
        logic [ACC_W-1:0] rx;
        logic [ACC_W-1:0] ry;
        logic [ACC_W-1:0] cx;
        logic [ACC_W-1:0] cy;
        logic [ACC_W-1:0] org_x;
        logic [ACC_W-1:0] org_y;
        logic [ACC_W-1:0] col_ofs_x;
        logic [ACC_W-1:0] col_ofs_y;
        logic [IDX_W-1:0] w_last;
        logic [IDX_W-1:0] h_last;
    } cfg_t;

    // first quarter wave of sin, 16.16, entries 0..QUARTER
    localparam logic [ACC_W-1:0] SINE_QTR [0:64] = '{
        32'h00000000, 32'h00000648, 32'h00000C8F, 32'h000012D5,
        32'h00001917, 32'h00001F56, 32'h00002590, 32'h00002BC4,
        32'h000031F1, 32'h00003817, 32'h00003E33, 32'h00004447,
        32'h00004A50, 32'h0000504D, 32'h0000563E, 32'h00005C22,
        32'h000061F7, 32'h000067BD, 32'h00006D74, 32'h00007319,
        32'h000078AD, 32'h00007E2E, 32'h0000839C, 32'h000088F5,
        32'h00008E39, 32'h00009368, 32'h0000987F, 32'h00009D7F,
        32'h0000A267, 32'h0000A736, 32'h0000ABEB, 32'h0000B085,
        32'h0000B504, 32'h0000B968, 32'h0000BDAE, 32'h0000C1D8,
        32'h0000C5E4, 32'h0000C9D1, 32'h0000CD9F, 32'h0000D14D,
        32'h0000D4DB, 32'h0000D848, 32'h0000DB94, 32'h0000DEBE,
        32'h0000E1C5, 32'h0000E4AA, 32'h0000E76B, 32'h0000EA09,
        32'h0000EC83, 32'h0000EED8, 32'h0000F109, 32'h0000F314,
        32'h0000F4FA, 32'h0000F6BA, 32'h0000F853, 32'h0000F9C7,
        32'h0000FB14, 32'h0000FC3B, 32'h0000FD3A, 32'h0000FE13,
        32'h0000FEC4, 32'h0000FF4E, 32'h0000FFB1, 32'h0000FFEC,
        32'h00010000
    };

    // full-wave lookup by quarter symmetry
    function automatic logic [ACC_W-1:0] sine_lookup(input logic [ANGLE_W-1:0] idx);
        logic [6:0]       qi;
        logic [ACC_W-1:0] v;
        qi = idx[6] ? (7'(QUARTER) - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
        v  = SINE_QTR[qi];
        return idx[7] ? (ACC_W'(0) - v) : v;
    endfunction

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [SIZE_W-1:0] eff_size(input logic [DIM_CFG_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            return SIZE_W'(MAX_DIM);
        end else begin
            return SIZE_W'(v);
        end
    endfunction

endpackage

[src/rotated_raster_coordinate_generator_core.sv]
`timescale 1ns / 1ps
// Top level of the rotated raster coordinate generator: stream ports and config write port.
// Depends on rrcg_pkg, rrcg_cfg and rrcg_gen.

// Each input transaction produces one result transaction: the rotated 16.16 source coordinate
// of the next pixel of a width-by-height raster in row-major order, shifted right by 8, with
// tuser marking the last pixel of a row and tlast the last pixel of the frame; the raster
// wraps to a new frame by itself, and frame_start restarts it at pixel zero. One transaction
// is taken per clock while s_tready is high; each input passes through the input register, then
// the accumulator update into the result register; while a result waits the input side takes
// one more transaction into its register and then holds s_tready low. After reset, and after
// any configuration write, s_tready stays low while the sine lookups and the origin multiplies
// settle.
module rotated_raster_coordinate_generator_core
    import rrcg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] frame_start, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [21:0] coord_x, [43:22] coord_y, [47:44] zero
    output logic                  m_tuser,   // row_end
    output logic                  m_tlast    // frame_end
);

    cfg_t               cfg;
    logic               cfg_busy;
    logic [COORD_W-1:0] coord_x, coord_y;

    rrcg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .cfg_busy  (cfg_busy)
    );

    rrcg_gen u_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cfg_busy      (cfg_busy),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_frame_start (s_tdata[0]),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_coord_x     (coord_x),
        .m_coord_y     (coord_y),
        .m_row_end     (m_tuser),
        .m_frame_end   (m_tlast)
    );

    assign m_tdata = {4'b0000, coord_y, coord_x};

endmodule

[src/rrcg_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers and the two-stage pipeline that derives step vectors and origins.
// Depends on rrcg_pkg.
module rrcg_cfg
    import rrcg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg,
    output logic                  cfg_busy
);

    logic [ANGLE_W-1:0]   angle_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic                 abs_mode_reg;
    logic [SETTLE_W-1:0]  settle_reg;

    // stage 1: table lookups and effective sizes
    logic [ACC_W-1:0]  rx_reg, ry_reg, cx_reg, cy_reg;
    logic [IDX_W-1:0]  hw_reg, hh_reg, w_last_reg, h_last_reg;
    logic              centred_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [ACC_W-1:0]  sin_val, cos_val, neg_val;

    // stage 2: origin and column offsets
    logic [ACC_W-1:0] org_x_reg, org_y_reg, col_ofs_x_reg, col_ofs_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg    <= ANGLE_RST;
            width_reg    <= DIM_RST;
            height_reg   <= DIM_RST;
            abs_mode_reg <= 1'b0;
            settle_reg   <= CFG_SETTLE;
        end else begin
            if (cfg_wr_en) begin
                settle_reg <= CFG_SETTLE;
                case (cfg_index_t'(cfg_addr))
                    REG_ANGLE:    angle_reg    <= cfg_wdata[ANGLE_W-1:0];
                    REG_WIDTH:    width_reg    <= cfg_wdata[DIM_CFG_W-1:0];
                    REG_HEIGHT:   height_reg   <= cfg_wdata[DIM_CFG_W-1:0];
                    REG_ABS_MODE: abs_mode_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    assign w_eff   = eff_size(width_reg);
    assign h_eff   = eff_size(height_reg);
    assign sin_val = sine_lookup(angle_reg);
    assign cos_val = sine_lookup(angle_reg + ANGLE_COS_OFS);
    assign neg_val = sine_lookup(angle_reg + ANGLE_NEG_OFS);

    always_ff @(posedge aclk) begin
        rx_reg      <= sin_val;
        ry_reg      <= cos_val;
        cx_reg      <= {cos_val[ACC_W-2:0], 1'b0};
        cy_reg      <= {neg_val[ACC_W-2:0], 1'b0};
        hw_reg      <= w_eff[SIZE_W-1:1];
        hh_reg      <= h_eff[SIZE_W-1:1];
        w_last_reg  <= IDX_W'(w_eff - SIZE_W'(1));
        h_last_reg  <= IDX_W'(h_eff - SIZE_W'(1));
        centred_reg <= ~abs_mode_reg;
    end

    always_ff @(posedge aclk) begin
        org_x_reg     <= centred_reg ? (ACC_W'(0) - rx_reg * ACC_W'(hw_reg)) : '0;
        org_y_reg     <= centred_reg ? (ACC_W'(0) - ry_reg * ACC_W'(hh_reg)) : '0;
        col_ofs_x_reg <= centred_reg ? (cx_reg * ACC_W'(hw_reg)) : '0;
        col_ofs_y_reg <= centred_reg ? (cy_reg * ACC_W'(hh_reg)) : '0;
    end

    assign cfg.rx        = rx_reg;
    assign cfg.ry        = ry_reg;
    assign cfg.cx        = cx_reg;
    assign cfg.cy        = cy_reg;
    assign cfg.org_x     = org_x_reg;
    assign cfg.org_y     = org_y_reg;
    assign cfg.col_ofs_x = col_ofs_x_reg;
    assign cfg.col_ofs_y = col_ofs_y_reg;
    assign cfg.w_last    = w_last_reg;
    assign cfg.h_last    = h_last_reg;
    assign cfg_busy      = (settle_reg != '0);

endmodule

[src/rrcg_gen.sv]
`timescale 1ns / 1ps
// Pixel walker: input register, raster counters, row/pixel accumulators, result register.
// Depends on rrcg_pkg.
module rrcg_gen
    import rrcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               cfg_busy,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_coord_x,
    output logic [COORD_W-1:0] m_coord_y,
    output logic               m_row_end,
    output logic               m_frame_end
);

    logic               in_valid_reg, in_fs_reg;
    logic [IDX_W-1:0]   col_reg, row_reg;
    logic [ACC_W-1:0]   rs_x_reg, rs_y_reg, pix_x_reg, pix_y_reg;
    logic               out_valid_reg, row_end_reg, frame_end_reg;
    logic [COORD_W-1:0] coord_x_reg, coord_y_reg;

    logic               advance;
    logic [IDX_W-1:0]   col_cur, row_cur, col_next, row_next;
    logic               first_col, last_col, last_row;
    logic [ACC_W-1:0]   rs_base_x, rs_base_y, pix_cur_x, pix_cur_y;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !cfg_busy && (!in_valid_reg || advance);

    always_comb begin
        col_cur   = in_fs_reg ? '0 : col_reg;
        row_cur   = in_fs_reg ? '0 : row_reg;
        first_col = (col_cur == '0);
        rs_base_x = (row_cur == '0) ? cfg.org_x : rs_x_reg;
        rs_base_y = (row_cur == '0) ? cfg.org_y : rs_y_reg;
        pix_cur_x = first_col ? (rs_base_x - cfg.col_ofs_x) : pix_x_reg;
        pix_cur_y = first_col ? (rs_base_y - cfg.col_ofs_y) : pix_y_reg;
        // an index past a shrunk size counts as the last one
        last_col  = (col_cur >= cfg.w_last);
        last_row  = (row_cur >= cfg.h_last);
        col_next  = last_col ? '0 : (col_cur + IDX_W'(1));
        row_next  = !last_col ? row_cur : (last_row ? '0 : (row_cur + IDX_W'(1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                col_reg       <= col_next;
                row_reg       <= row_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_fs_reg <= s_frame_start;
        end
        if (advance) begin
            if (first_col) begin
                rs_x_reg <= rs_base_x + cfg.rx;
                rs_y_reg <= rs_base_y + cfg.ry;
            end
            pix_x_reg     <= pix_cur_x + cfg.cx;
            pix_y_reg     <= pix_cur_y + cfg.cy;
            // arithmetic shift then keep the low bits
            coord_x_reg   <= pix_cur_x[COORD_SHIFT+COORD_W-1:COORD_SHIFT];
            coord_y_reg   <= pix_cur_y[COORD_SHIFT+COORD_W-1:COORD_SHIFT];
            row_end_reg   <= last_col;
            frame_end_reg <= last_col && last_row;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_coord_x   = coord_x_reg;
    assign m_coord_y   = coord_y_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

[src/rrcg_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the rotated raster coordinate generator, bound to the top level.
// Depends on rrcg_pkg.
module rrcg_checker
    import rrcg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [47:0]           m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // the last pixel of a frame is always the last of its row
    a_frame_end_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("frame end without row end");

    // derived config settles before any new transaction is taken
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted right after a config write");

    // no result comes out of reset
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its payload
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind rotated_raster_coordinate_generator_core rrcg_checker u_rrcg_checker (.*);

[test/rotated_raster_coordinate_generator_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rotated_raster_coordinate_generator_core: directed and random
// pixel streams checked against a cycle-free raster predictor. Depends on rrcg_pkg.
module rotated_raster_coordinate_generator_core_test;
    import rrcg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 500;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic               row_end;
        logic               frame_end;
    } pixel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] frame_start, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // [21:0] coord_x, [43:22] coord_y, [47:44] zero
    logic                  m_tuser;   // row_end
    logic                  m_tlast;   // frame_end

    rotated_raster_coordinate_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // first quarter of the sine wave, unsigned 1.16
    logic [16:0] quarter_sine [0:64] = '{
        17'h00000, 17'h00648, 17'h00C8F, 17'h012D5, 17'h01917, 17'h01F56, 17'h02590, 17'h02BC4,
        17'h031F1, 17'h03817, 17'h03E33, 17'h04447, 17'h04A50, 17'h0504D, 17'h0563E, 17'h05C22,
        17'h061F7, 17'h067BD, 17'h06D74, 17'h07319, 17'h078AD, 17'h07E2E, 17'h0839C, 17'h088F5,
        17'h08E39, 17'h09368, 17'h0987F, 17'h09D7F, 17'h0A267, 17'h0A736, 17'h0ABEB, 17'h0B085,
        17'h0B504, 17'h0B968, 17'h0BDAE, 17'h0C1D8, 17'h0C5E4, 17'h0C9D1, 17'h0CD9F, 17'h0D14D,
        17'h0D4DB, 17'h0D848, 17'h0DB94, 17'h0DEBE, 17'h0E1C5, 17'h0E4AA, 17'h0E76B, 17'h0EA09,
        17'h0EC83, 17'h0EED8, 17'h0F109, 17'h0F314, 17'h0F4FA, 17'h0F6BA, 17'h0F853, 17'h0F9C7,
        17'h0FB14, 17'h0FC3B, 17'h0FD3A, 17'h0FE13, 17'h0FEC4, 17'h0FF4E, 17'h0FFB1, 17'h0FFEC,
        17'h10000
    };

    // predictor copy of the registers and the raster walk
    logic [ANGLE_W-1:0]   angle_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic                 absolute_reg;
    logic [ACC_W-1:0]     line_x, line_y, walk_x, walk_y;
    int unsigned          col_pos, row_pos;

    pixel_t      expected_pixels [$];
    pixel_t      head_pixel;
    int          errors;
    int          items_sent;
    int          pixels_checked;
    int          row_ends_seen;
    int          frame_ends_seen;
    int          phases_run;
    int          idle_cycles;
    bit          idle_enable;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ACC_W-1:0] sine_q16(input logic [ANGLE_W-1:0] turn);
        int          fold;
        logic [31:0] mag;
        fold = turn[6:0];
        if (fold > 64) fold = 128 - fold;
        mag = {15'd0, quarter_sine[fold]};
        return turn[7] ? (32'd0 - mag) : mag;
    endfunction

    function automatic logic [31:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
        if (v == 0) return 32'd1;
        if (v > MAX_DIM) return 32'(MAX_DIM);
        return 32'(v);
    endfunction

    function automatic logic [COORD_W-1:0] shift_coord(input logic [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        s = $signed(acc) >>> COORD_SHIFT;
        return s[COORD_W-1:0];
    endfunction

    // one raster step: works out the pixel for an accepted input and queues it
    task automatic advance_raster(input logic frame_start);
        logic [31:0] w, h, hw, hh, rx, ry, cx, cy;
        logic        centred, last_col, last_row;
        pixel_t      px;
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        hw = w / 2;
        hh = h / 2;
        rx = sine_q16(angle_reg);
        ry = sine_q16(angle_reg + ANGLE_COS_OFS);
        cx = ry << 1;
        cy = sine_q16(angle_reg + ANGLE_NEG_OFS) << 1;
        centred = !absolute_reg;
        if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos == 0) begin
            if (row_pos == 0) begin
                line_x = centred ? 32'd0 - rx * hw : 32'd0;
                line_y = centred ? 32'd0 - ry * hh : 32'd0;
            end
            walk_x = line_x;
            walk_y = line_y;
            if (centred) begin
                walk_x = walk_x - cx * hw;
                walk_y = walk_y - cy * hh;
            end
            line_x = line_x + rx;
            line_y = line_y + ry;
        end
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        px.coord_x   = shift_coord(walk_x);
        px.coord_y   = shift_coord(walk_y);
        px.row_end   = last_col;
        px.frame_end = last_col && last_row;
        expected_pixels.push_back(px);
        walk_x = walk_x + cx;
        walk_y = walk_y + cy;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic frame_start);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, frame_start};
        do @(posedge aclk); while (!s_tready);
        advance_raster(frame_start);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait for every queued pixel, then let the pipeline go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // back-to-back writes keep the enable high; cfg_release lowers it
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_ANGLE:    angle_reg    = value[ANGLE_W-1:0];
            REG_WIDTH:    width_reg    = value;
            REG_HEIGHT:   height_reg   = value;
            REG_ABS_MODE: absolute_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_wr_en <= 1'b0;
    endtask

    // first transactions after reset start a frame without frame_start
    task automatic test_reset_defaults();
        repeat (3) send_pixel(1'b0);
        drain();
    endtask

    // zero sizes act as one; upper data bits of narrow registers are dropped
    task automatic test_smallest_raster();
        cfg_write(REG_WIDTH, 11'd0);
        cfg_write(REG_HEIGHT, 11'd0);
        cfg_write(REG_ANGLE, 11'h7A5);
        cfg_write(REG_ABS_MODE, 11'h7FF);
        cfg_release();
        repeat (3) send_pixel(1'b0);
        drain();
        cfg_write(REG_ABS_MODE, 11'h7FE);
        cfg_release();
        send_pixel(1'b1);
        send_pixel(1'b0);
        drain();
    endtask

    // sizes above the maximum clamp; restart mid-row
    task automatic test_largest_raster();
        cfg_write(REG_WIDTH, 11'h7FF);
        cfg_write(REG_HEIGHT, 11'd1025);
        cfg_write(REG_ANGLE, 11'h0FF);
        cfg_release();
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        drain();
        cfg_write(REG_WIDTH, 11'd1024);
        cfg_write(REG_HEIGHT, 11'd1024);
        cfg_write(REG_ANGLE, 11'h040);
        cfg_write(REG_ABS_MODE, 11'd1);
        cfg_release();
        repeat (3) send_pixel(1'b0);
        drain();
    endtask

    // shrinking the raster while the walk is past the new last column/row
    task automatic test_shrink_midframe();
        cfg_write(REG_WIDTH, 11'd6);
        cfg_write(REG_HEIGHT, 11'd3);
        cfg_write(REG_ANGLE, 11'h080);
        cfg_write(REG_ABS_MODE, 11'd0);
        cfg_release();
        send_pixel(1'b1);
        repeat (4) send_pixel(1'b0);
        drain();
        cfg_write(REG_WIDTH, 11'd2);
        cfg_release();
        repeat (2) send_pixel(1'b0);
        drain();
        cfg_write(REG_HEIGHT, 11'd1);
        cfg_release();
        repeat (2) send_pixel(1'b0);
        drain();
    endtask

    function automatic logic [DIM_CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return 11'd0;
        if (r < 12) return 11'd1024;
        if (r < 16) return 11'($urandom_range(1025, 2047));
        if (r < 26) return 11'($urandom_range(13, 80));
        return 11'($urandom_range(1, 12));
    endfunction

    task automatic test_random_frames();
        int  sent, n, kind, k;
        bit  first;
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (first || $urandom_range(0, 9) < 6)
                cfg_write(REG_ANGLE, 11'($urandom_range(0, 2047)));
            if (first || $urandom_range(0, 9) < 6) cfg_write(REG_WIDTH, pick_dim());
            if (first || $urandom_range(0, 9) < 6) cfg_write(REG_HEIGHT, pick_dim());
            if (first || $urandom_range(0, 9) < 5)
                cfg_write(REG_ABS_MODE, 11'($urandom_range(0, 2047)));
            cfg_release();
            first       = 1'b0;
            idle_enable = $urandom_range(0, 9) < 8;
            n    = $urandom_range(16, 60);
            kind = $urandom_range(0, 99);
            for (k = 0; k < n; k++) begin
                if (kind < 60)
                    send_pixel(k == 0);            // clean frames from pixel zero
                else if (kind < 80)
                    send_pixel(1'b0);              // carry on from the current position
                else
                    send_pixel($urandom_range(0, 99) < 15);
            end
            sent += n;
            phases_run++;
            drain();
        end
        idle_enable = 1'b1;
    endtask

    // receiver back-pressure
    initial begin
        int unsigned hold;
        int          r;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!idle_enable) begin
                m_tready <= 1'b1;
                hold = 0;
            end else if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(1, 8);
                end else if (r < 93) begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end else begin
                hold--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction x=%0d y=%0d", $time,
                         $signed(m_tdata[21:0]), $signed(m_tdata[43:22]));
            end else begin
                head_pixel = expected_pixels.pop_front();
                pixels_checked++;
                if (m_tuser) row_ends_seen++;
                if (m_tlast) frame_ends_seen++;
                if (m_tdata[21:0] !== head_pixel.coord_x) begin
                    errors++;
                    $display("%0t: coord_x expected %0d actual %0d", $time,
                             $signed(head_pixel.coord_x), $signed(m_tdata[21:0]));
                end
                if (m_tdata[43:22] !== head_pixel.coord_y) begin
                    errors++;
                    $display("%0t: coord_y expected %0d actual %0d", $time,
                             $signed(head_pixel.coord_y), $signed(m_tdata[43:22]));
                end
                if (m_tuser !== head_pixel.row_end) begin
                    errors++;
                    $display("%0t: row_end expected %0b actual %0b", $time,
                             head_pixel.row_end, m_tuser);
                end
                if (m_tlast !== head_pixel.frame_end) begin
                    errors++;
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             head_pixel.frame_end, m_tlast);
                end
            end
        end
    end

    // stall watchdog: cycles without any transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = REG_ANGLE;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        angle_reg       = ANGLE_RST;
        width_reg       = DIM_RST;
        height_reg      = DIM_RST;
        absolute_reg    = 1'b0;
        line_x          = '0;
        line_y          = '0;
        walk_x          = '0;
        walk_y          = '0;
        col_pos         = 0;
        row_pos         = 0;
        errors          = 0;
        items_sent      = 0;
        pixels_checked  = 0;
        row_ends_seen   = 0;
        frame_ends_seen = 0;
        phases_run      = 0;
        idle_cycles     = 0;
        idle_enable     = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_smallest_raster();
        test_largest_raster();
        test_shrink_midframe();
        test_random_frames();

        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d pixel transactions over %0d random config phases plus directed cases",
                 items_sent, phases_run);
        $display("Checked %0d results: %0d row ends, %0d frame ends",
                 pixels_checked, row_ends_seen, frame_ends_seen);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
